// ----- src/c8_pkg.sv -----
// shared constants, types and helper functions of the chip8 core
package c8_pkg;

  localparam int ADDR_W        = 12;
  localparam int MEM_BYTES     = 4096;
  localparam int PROGRAM_START = 512;
  localparam int FONT_BASE     = 80;
  localparam int FONT_LEN      = 80;
  localparam int SCREEN_W      = 64;
  localparam int SCREEN_H      = 32;
  localparam int ROW_W         = $clog2(SCREEN_H);
  localparam int XPOS_W        = $clog2(SCREEN_W);
  localparam int STACK_ENTRIES = 16;
  localparam int STK_AW        = $clog2(STACK_ENTRIES);
  localparam int SP_W          = 5;
  localparam int CNT_W         = $clog2(MEM_BYTES);

  // item commands
  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_STEP = 2'd1;
  localparam logic [1:0] CMD_ROW  = 2'd2;
  localparam logic [1:0] CMD_NOP  = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_BAD = 2'd1;
  localparam logic [1:0] ST_OVF = 2'd2;
  localparam logic [1:0] ST_UNF = 2'd3;

  // opcode groups, top nibble
  localparam logic [3:0] OP_SYS  = 4'h0;
  localparam logic [3:0] OP_JP   = 4'h1;
  localparam logic [3:0] OP_CALL = 4'h2;
  localparam logic [3:0] OP_SE   = 4'h3;
  localparam logic [3:0] OP_SNE  = 4'h4;
  localparam logic [3:0] OP_SER  = 4'h5;
  localparam logic [3:0] OP_LD   = 4'h6;
  localparam logic [3:0] OP_ADD  = 4'h7;
  localparam logic [3:0] OP_ALU  = 4'h8;
  localparam logic [3:0] OP_SNER = 4'h9;
  localparam logic [3:0] OP_LDI  = 4'hA;
  localparam logic [3:0] OP_JPV  = 4'hB;
  localparam logic [3:0] OP_RND  = 4'hC;
  localparam logic [3:0] OP_DRW  = 4'hD;
  localparam logic [3:0] OP_SKP  = 4'hE;
  localparam logic [3:0] OP_MISC = 4'hF;

  localparam logic [15:0] SYS_CLS = 16'h00E0;
  localparam logic [15:0] SYS_RET = 16'h00EE;

  // register-register operations, low nibble
  localparam logic [3:0] ALU_MOV  = 4'h0;
  localparam logic [3:0] ALU_OR   = 4'h1;
  localparam logic [3:0] ALU_AND  = 4'h2;
  localparam logic [3:0] ALU_XOR  = 4'h3;
  localparam logic [3:0] ALU_ADD  = 4'h4;
  localparam logic [3:0] ALU_SUB  = 4'h5;
  localparam logic [3:0] ALU_SHR  = 4'h6;
  localparam logic [3:0] ALU_SUBN = 4'h7;
  localparam logic [3:0] ALU_SHL  = 4'hE;

  localparam logic [7:0] E_SKP  = 8'h9E;
  localparam logic [7:0] E_SKNP = 8'hA1;

  localparam logic [7:0] F_GDT   = 8'h07;
  localparam logic [7:0] F_KEY   = 8'h0A;
  localparam logic [7:0] F_SDT   = 8'h15;
  localparam logic [7:0] F_SST   = 8'h18;
  localparam logic [7:0] F_ADDI  = 8'h1E;
  localparam logic [7:0] F_FONT  = 8'h29;
  localparam logic [7:0] F_BCD   = 8'h33;
  localparam logic [7:0] F_STORE = 8'h55;
  localparam logic [7:0] F_LOAD  = 8'h65;

  localparam logic [7:0] FONT [FONT_LEN] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  // long operations that follow the execute cycle
  typedef enum logic [2:0] {
    K_NONE, K_CLS, K_RET, K_DRAW, K_BCD, K_STORE, K_LOAD
  } kind_t;

  typedef enum logic [1:0] {MR_PC, MR_PC1, MR_IDX} mrd_sel_t;
  typedef enum logic [2:0] {MW_NONE, MW_INIT, MW_LOAD, MW_BCD, MW_STORE} mwr_sel_t;
  typedef enum logic [1:0] {VR_X, VR_Y, VR_CNT} vrd_sel_t;
  typedef enum logic [2:0] {VW_NONE, VW_INIT, VW_VX, VW_HIT, VW_LOAD} vwr_sel_t;
  typedef enum logic {FR_SEL, FR_DRAW} frd_sel_t;
  typedef enum logic [1:0] {FW_NONE, FW_INIT, FW_CLR, FW_DRAW} fwr_sel_t;

  typedef struct packed {
    logic     take;
    logic     cnt_clr;
    logic     cnt_inc;
    mrd_sel_t mrd;
    mwr_sel_t mwr;
    vrd_sel_t vrd;
    vwr_sel_t vwr;
    logic     fr_rd;
    frd_sel_t frd;
    fwr_sel_t fwr;
    logic     op_hi;
    logic     op_lo;
    logic     pc_adv;
    logic     vx_cap;
    logic     exec;
    logic     ret_pc;
    logic     tick;
    logic     out_load;
  } c8_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  wr_vx;
    logic  draw_done;
    logic  cnt_init_last;
    logic  cnt_row_last;
    logic  cnt_bcd_last;
    logic  cnt_x_last;
  } c8_stat_t;

  // reset content of main memory
  function automatic logic [7:0] font_byte(input logic [ADDR_W-1:0] addr);
    logic [ADDR_W-1:0] off;
    off = addr - ADDR_W'(FONT_BASE);
    if (addr >= ADDR_W'(FONT_BASE) && addr < ADDR_W'(FONT_BASE + FONT_LEN)) begin
      return FONT[off[6:0]];
    end
    return 8'h00;
  endfunction

  // decimal digits {hundreds, tens, ones}
  function automatic logic [11:0] bcd3(input logic [7:0] v);
    logic [1:0]  h;
    logic [7:0]  r;
    logic [14:0] p;
    logic [3:0]  t;
    logic [7:0]  o;
    if (v >= 8'd200) begin
      h = 2'd2;
      r = v - 8'd200;
    end else if (v >= 8'd100) begin
      h = 2'd1;
      r = v - 8'd100;
    end else begin
      h = 2'd0;
      r = v;
    end
    p = 15'(r[6:0]) * 15'd205;
    t = p[14:11];
    o = r - 8'(t) * 8'd10;
    return {2'b00, h, t, o[3:0]};
  endfunction

endpackage

// ----- src/c8_req_if.sv -----
// request channel: item fields with valid/ready
interface c8_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [11:0] load_address;
  logic [7:0]  load_byte;
  logic [15:0] key_state;
  logic [7:0]  random_byte;
  logic [4:0]  row_select;

  modport source (output valid, cmd, load_address, load_byte, key_state, random_byte,
                  row_select, input ready);
  modport sink (input valid, cmd, load_address, load_byte, key_state, random_byte,
                row_select, output ready);
endinterface

// ----- src/c8_rsp_if.sv -----
// response channel: result fields with valid/ready
interface c8_rsp_if;
  logic        valid;
  logic        ready;
  logic [11:0] program_counter;
  logic [15:0] fetched_opcode;
  logic [1:0]  status;
  logic        waiting_for_key;
  logic        sound_on;
  logic [63:0] pixel_row;

  modport source (output valid, program_counter, fetched_opcode, status,
                  waiting_for_key, sound_on, pixel_row, input ready);
  modport sink (input valid, program_counter, fetched_opcode, status,
                waiting_for_key, sound_on, pixel_row, output ready);
endinterface

// ----- src/chip8_interpreter_core_top.sv -----
// chip8 interpreter core top level: controller plus datapath
//
//   channel | dir | word                                      | handshake
//   req     | in  | cmd, load_address, load_byte, key_state,  | valid/ready
//           |     | random_byte, row_select                   |
//   rsp     | out | program_counter, fetched_opcode, status,  | valid/ready
//           |     | waiting_for_key, sound_on, pixel_row      |
//
// after reset a clearing pass writes the font and zeros into main memory,
// zeros the display rows and the v registers; req.ready is low meanwhile
// load, read-row and no-op words go straight to the response; a step
// fetches the opcode, reads Vx and Vy, executes, then may add a register
// write, a return, a screen clear, a read and write per sprite row drawn
// (none for a zero-row sprite), a decimal store, or a read and write per
// register for register store/load; the step sequence is set by the main
// memory and v register file, each with a registered read
// one word is in flight at a time; a finished word sits in the response
// register while the next request word is taken
module chip8_interpreter_core_top (
  input logic      clk,
  input logic      rst,
  c8_req_if.sink   req,
  c8_rsp_if.source rsp
);

  c8_pkg::c8_cmd_t  cmd;
  c8_pkg::c8_stat_t stat;

  // sequencer
  c8_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_cmd   (req.cmd),
    .req_ready (req.ready),
    .rsp_ready (rsp.ready),
    .rsp_valid (rsp.valid),
    .cmd       (cmd),
    .stat      (stat)
  );

  // machine state, memories and execute logic
  c8_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .in_cmd       (req.cmd),
    .load_address (req.load_address),
    .load_byte    (req.load_byte),
    .key_state    (req.key_state),
    .random_byte  (req.random_byte),
    .row_select   (req.row_select),
    .out_pc       (rsp.program_counter),
    .out_op       (rsp.fetched_opcode),
    .out_status   (rsp.status),
    .out_wait     (rsp.waiting_for_key),
    .out_sound    (rsp.sound_on),
    .out_row      (rsp.pixel_row)
  );

endmodule

// ----- src/c8_dpath.sv -----
// datapath: memories, machine registers, decode and execute
module c8_dpath (
  input  logic              clk,
  input  logic              rst,
  input  c8_pkg::c8_cmd_t   cmd,
  output c8_pkg::c8_stat_t  stat,
  input  logic [1:0]        in_cmd,
  input  logic [11:0]       load_address,
  input  logic [7:0]        load_byte,
  input  logic [15:0]       key_state,
  input  logic [7:0]        random_byte,
  input  logic [4:0]        row_select,
  output logic [11:0]       out_pc,
  output logic [15:0]       out_op,
  output logic [1:0]        out_status,
  output logic              out_wait,
  output logic              out_sound,
  output logic [63:0]       out_row
);

  logic [7:0]  mem [c8_pkg::MEM_BYTES];
  logic [7:0]  vreg [16];
  logic [c8_pkg::SCREEN_W-1:0] frame [c8_pkg::SCREEN_H];
  logic [11:0] stk [c8_pkg::STACK_ENTRIES];

  logic [11:0] pc;
  logic [15:0] ireg;
  logic [c8_pkg::SP_W-1:0] sp;
  logic [7:0]  dt, st;
  logic [15:0] op;
  logic [7:0]  vx, vy, res_r;
  logic [15:0] keys;
  logic [7:0]  rnd;
  logic [1:0]  cmd_r;
  logic [c8_pkg::CNT_W-1:0] cnt;
  logic        hit;
  logic [1:0]  status_r;
  logic        wait_r;
  logic [7:0]  mem_q, v_q;
  logic [c8_pkg::SCREEN_W-1:0] fr_q;
  logic [11:0] stk_q;

  // decode results
  logic [11:0] pc_x;
  logic [15:0] i_x;
  logic [c8_pkg::SP_W-1:0] sp_x;
  logic [7:0]  dt_x, st_x, res, vf_val;
  logic [1:0]  code;
  logic        wait_x, wr_vx, wr_vf, stk_wr, bad, found;
  logic [3:0]  kidx;
  c8_pkg::kind_t kind;

  logic [3:0]  x, n;
  logic [7:0]  kk;
  logic [11:0] nnn, pc2;
  logic [8:0]  sum9;
  logic        key_hit;

  logic [c8_pkg::ROW_W:0] draw_row;
  logic [c8_pkg::SCREEN_W-1:0] spr;
  logic [11:0] idx_addr;
  logic [11:0] bcd;
  logic [c8_pkg::SP_W-1:0] sp_m1;

  logic        m_we;
  logic [11:0] m_wa, m_ra;
  logic [7:0]  m_wd;
  logic        v_we;
  logic [3:0]  v_wa, v_ra;
  logic [7:0]  v_wd;
  logic        f_we;
  logic [c8_pkg::ROW_W-1:0] f_wa, f_ra;
  logic [c8_pkg::SCREEN_W-1:0] f_wd;

  assign x        = op[11:8];
  assign n        = op[3:0];
  assign kk       = op[7:0];
  assign nnn      = op[11:0];
  assign pc2      = pc + 12'd2;
  assign sum9     = {1'b0, vx} + {1'b0, v_q};
  assign key_hit  = (vx[7:4] == 4'h0) && keys[vx[3:0]];
  assign idx_addr = ireg[11:0] + cnt[11:0];
  assign bcd      = c8_pkg::bcd3(vx);
  assign sp_m1    = sp - c8_pkg::SP_W'(1);
  assign draw_row = {1'b0, vy[c8_pkg::ROW_W-1:0]} + {1'b0, cnt[c8_pkg::ROW_W-1:0]};
  assign spr      = {mem_q, {(c8_pkg::SCREEN_W-8){1'b0}}} >> vx[c8_pkg::XPOS_W-1:0];

  // highest held key
  always_comb begin
    found = 1'b0;
    kidx  = 4'h0;
    for (int i = 0; i < 16; i++) begin
      if (keys[i]) begin
        found = 1'b1;
        kidx  = 4'(i);
      end
    end
  end

  // instruction decode and execute; v_q holds Vy (V0 for jump offset)
  always_comb begin
    pc_x   = pc;
    i_x    = ireg;
    sp_x   = sp;
    dt_x   = dt;
    st_x   = st;
    res    = 8'h00;
    vf_val = 8'h00;
    code   = c8_pkg::ST_OK;
    wait_x = 1'b0;
    wr_vx  = 1'b0;
    wr_vf  = 1'b0;
    stk_wr = 1'b0;
    bad    = 1'b0;
    kind   = c8_pkg::K_NONE;
    unique case (op[15:12])
      c8_pkg::OP_SYS: begin
        if (op == c8_pkg::SYS_CLS) begin
          kind = c8_pkg::K_CLS;
        end else if (op == c8_pkg::SYS_RET) begin
          if (sp == '0) begin
            code = c8_pkg::ST_UNF;
          end else begin
            sp_x = sp_m1;
            kind = c8_pkg::K_RET;
          end
        end else begin
          bad = 1'b1;
        end
      end
      c8_pkg::OP_JP: pc_x = nnn;
      c8_pkg::OP_CALL: begin
        if (sp >= c8_pkg::SP_W'(c8_pkg::STACK_ENTRIES)) begin
          code = c8_pkg::ST_OVF;
        end else begin
          stk_wr = 1'b1;
          sp_x   = sp + c8_pkg::SP_W'(1);
          pc_x   = nnn;
        end
      end
      c8_pkg::OP_SE:  if (vx == kk) pc_x = pc2;
      c8_pkg::OP_SNE: if (vx != kk) pc_x = pc2;
      c8_pkg::OP_SER: begin
        if (n != 4'h0) bad = 1'b1;
        else if (vx == v_q) pc_x = pc2;
      end
      c8_pkg::OP_LD: begin
        res   = kk;
        wr_vx = 1'b1;
      end
      c8_pkg::OP_ADD: begin
        res   = vx + kk;
        wr_vx = 1'b1;
      end
      c8_pkg::OP_ALU: begin
        wr_vx = 1'b1;
        unique case (n)
          c8_pkg::ALU_MOV: res = v_q;
          c8_pkg::ALU_OR:  res = vx | v_q;
          c8_pkg::ALU_AND: res = vx & v_q;
          c8_pkg::ALU_XOR: res = vx ^ v_q;
          c8_pkg::ALU_ADD: begin
            res    = sum9[7:0];
            wr_vf  = 1'b1;
            vf_val = {7'b0, sum9[8]};
          end
          c8_pkg::ALU_SUB: begin
            res    = vx - v_q;
            wr_vf  = 1'b1;
            vf_val = {7'b0, vx > v_q};
          end
          c8_pkg::ALU_SHR: begin
            res    = {1'b0, vx[7:1]};
            wr_vf  = 1'b1;
            vf_val = {7'b0, vx[0]};
          end
          c8_pkg::ALU_SUBN: begin
            res    = v_q - vx;
            wr_vf  = 1'b1;
            vf_val = {7'b0, v_q > vx};
          end
          c8_pkg::ALU_SHL: begin
            res    = {vx[6:0], 1'b0};
            wr_vf  = 1'b1;
            vf_val = {7'b0, vx[7]};
          end
          default: begin
            bad   = 1'b1;
            wr_vx = 1'b0;
          end
        endcase
      end
      c8_pkg::OP_SNER: begin
        if (n != 4'h0) bad = 1'b1;
        else if (vx != v_q) pc_x = pc2;
      end
      c8_pkg::OP_LDI: i_x = {4'h0, nnn};
      c8_pkg::OP_JPV: pc_x = nnn + {4'h0, v_q};
      c8_pkg::OP_RND: begin
        res   = rnd & kk;
        wr_vx = 1'b1;
      end
      c8_pkg::OP_DRW: begin
        if (n == 4'h0) wr_vf = 1'b1;
        else kind = c8_pkg::K_DRAW;
      end
      c8_pkg::OP_SKP: begin
        if (kk == c8_pkg::E_SKP) begin
          if (key_hit) pc_x = pc2;
        end else if (kk == c8_pkg::E_SKNP) begin
          if (!key_hit) pc_x = pc2;
        end else begin
          bad = 1'b1;
        end
      end
      c8_pkg::OP_MISC: begin
        unique case (kk)
          c8_pkg::F_GDT: begin
            res   = dt;
            wr_vx = 1'b1;
          end
          c8_pkg::F_KEY: begin
            if (found) begin
              res   = {4'h0, kidx};
              wr_vx = 1'b1;
            end else begin
              pc_x   = pc - 12'd2;
              wait_x = 1'b1;
            end
          end
          c8_pkg::F_SDT:   dt_x = vx;
          c8_pkg::F_SST:   st_x = vx;
          c8_pkg::F_ADDI:  i_x = ireg + {8'h00, vx};
          c8_pkg::F_FONT:  i_x = 16'(c8_pkg::FONT_BASE) + {10'h0, vx[3:0], 2'b00}
                                 + {12'h0, vx[3:0]};
          c8_pkg::F_BCD:   kind = c8_pkg::K_BCD;
          c8_pkg::F_STORE: kind = c8_pkg::K_STORE;
          c8_pkg::F_LOAD:  kind = c8_pkg::K_LOAD;
          default:         bad = 1'b1;
        endcase
      end
      default: bad = 1'b1;
    endcase
    if (bad) code = c8_pkg::ST_BAD;
  end

  always_comb begin
    stat.kind          = kind;
    stat.wr_vx         = wr_vx;
    stat.draw_done     = draw_row[c8_pkg::ROW_W] || (cnt[4:0] == {1'b0, n});
    stat.cnt_init_last = (cnt == c8_pkg::CNT_W'(c8_pkg::MEM_BYTES - 1));
    stat.cnt_row_last  = (cnt[c8_pkg::ROW_W-1:0] == c8_pkg::ROW_W'(c8_pkg::SCREEN_H - 1));
    stat.cnt_bcd_last  = (cnt[1:0] == 2'd2);
    stat.cnt_x_last    = (cnt[3:0] == x);
  end

  // port muxes
  always_comb begin
    unique case (cmd.mrd)
      c8_pkg::MR_PC:  m_ra = pc;
      c8_pkg::MR_PC1: m_ra = pc + 12'd1;
      c8_pkg::MR_IDX: m_ra = idx_addr;
      default:        m_ra = pc;
    endcase
    m_we = 1'b1;
    unique case (cmd.mwr)
      c8_pkg::MW_INIT: begin
        m_wa = cnt[11:0];
        m_wd = c8_pkg::font_byte(cnt[11:0]);
      end
      c8_pkg::MW_LOAD: begin
        m_wa = load_address;
        m_wd = load_byte;
      end
      c8_pkg::MW_BCD: begin
        m_wa = idx_addr;
        unique case (cnt[1:0])
          2'd0:    m_wd = {4'h0, bcd[11:8]};
          2'd1:    m_wd = {4'h0, bcd[7:4]};
          default: m_wd = {4'h0, bcd[3:0]};
        endcase
      end
      c8_pkg::MW_STORE: begin
        m_wa = idx_addr;
        m_wd = v_q;
      end
      default: begin
        m_we = 1'b0;
        m_wa = idx_addr;
        m_wd = v_q;
      end
    endcase
  end

  always_comb begin
    unique case (cmd.vrd)
      c8_pkg::VR_X:   v_ra = x;
      c8_pkg::VR_Y:   v_ra = (op[15:12] == c8_pkg::OP_JPV) ? 4'h0 : op[7:4];
      c8_pkg::VR_CNT: v_ra = cnt[3:0];
      default:        v_ra = x;
    endcase
    v_we = 1'b1;
    unique case (cmd.vwr)
      c8_pkg::VW_INIT: begin
        v_wa = cnt[3:0];
        v_wd = 8'h00;
      end
      c8_pkg::VW_VX: begin
        v_wa = x;
        v_wd = res_r;
      end
      c8_pkg::VW_HIT: begin
        v_wa = 4'hF;
        v_wd = {7'b0, hit};
      end
      c8_pkg::VW_LOAD: begin
        v_wa = cnt[3:0];
        v_wd = mem_q;
      end
      default: begin
        v_we = cmd.exec && wr_vf;
        v_wa = 4'hF;
        v_wd = vf_val;
      end
    endcase
  end

  always_comb begin
    f_ra = (cmd.frd == c8_pkg::FR_DRAW) ? draw_row[c8_pkg::ROW_W-1:0] : row_select;
    f_we = 1'b1;
    f_wa = cnt[c8_pkg::ROW_W-1:0];
    f_wd = '0;
    unique case (cmd.fwr)
      c8_pkg::FW_INIT, c8_pkg::FW_CLR: ;
      c8_pkg::FW_DRAW: begin
        f_wa = draw_row[c8_pkg::ROW_W-1:0];
        f_wd = fr_q ^ spr;
      end
      default: f_we = 1'b0;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (m_we) mem[m_wa] <= m_wd;
    mem_q <= mem[m_ra];
  end

  always_ff @(posedge clk) begin
    if (v_we) vreg[v_wa] <= v_wd;
    v_q <= vreg[v_ra];
  end

  always_ff @(posedge clk) begin
    if (f_we) frame[f_wa] <= f_wd;
    if (cmd.fr_rd) fr_q <= frame[f_ra];
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && stk_wr) stk[sp[c8_pkg::STK_AW-1:0]] <= pc;
    stk_q <= stk[sp_m1[c8_pkg::STK_AW-1:0]];
  end

  // machine registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pc   <= 12'(c8_pkg::PROGRAM_START);
      ireg <= '0;
      sp   <= '0;
      dt   <= '0;
      st   <= '0;
      cnt  <= '0;
    end else begin
      if (cmd.cnt_clr) cnt <= '0;
      else if (cmd.cnt_inc) cnt <= cnt + c8_pkg::CNT_W'(1);
      if (cmd.pc_adv) pc <= pc2;
      if (cmd.ret_pc) pc <= stk_q;
      if (cmd.exec) begin
        pc   <= pc_x;
        ireg <= i_x;
        sp   <= sp_x;
        dt   <= dt_x;
        st   <= st_x;
      end
      if (cmd.tick) begin
        if (dt != 8'h00) dt <= dt - 8'd1;
        if (st != 8'h00) st <= st - 8'd1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      cmd_r <= in_cmd;
      keys  <= key_state;
      rnd   <= random_byte;
    end
    if (cmd.op_hi) op[15:8] <= mem_q;
    if (cmd.op_lo) op[7:0]  <= mem_q;
    if (cmd.vx_cap) vx <= v_q;
    if (cmd.exec) begin
      vy       <= v_q;
      res_r    <= res;
      status_r <= code;
      wait_r   <= wait_x;
    end
    if (cmd.cnt_clr) hit <= 1'b0;
    else if (cmd.fwr == c8_pkg::FW_DRAW) hit <= hit | (|(fr_q & spr));
    if (cmd.out_load) begin
      out_pc     <= pc;
      out_op     <= (cmd_r == c8_pkg::CMD_STEP) ? op : 16'h0000;
      out_status <= (cmd_r == c8_pkg::CMD_STEP) ? status_r : c8_pkg::ST_OK;
      out_wait   <= (cmd_r == c8_pkg::CMD_STEP) && wait_r;
      out_sound  <= (st != 8'h00);
      out_row    <= (cmd_r == c8_pkg::CMD_ROW) ? fr_q : '0;
    end
  end

endmodule

// ----- src/c8_ctrl.sv -----
// controller: sequencer state machine and response valid
module c8_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  input  logic [1:0]       req_cmd,
  output logic             req_ready,
  input  logic             rsp_ready,
  output logic             rsp_valid,
  output c8_pkg::c8_cmd_t  cmd,
  input  c8_pkg::c8_stat_t stat
);

  typedef enum logic [20:0] {
    S_INIT    = 21'h000001,
    S_IDLE    = 21'h000002,
    S_FETCH0  = 21'h000004,
    S_FETCH1  = 21'h000008,
    S_FETCH2  = 21'h000010,
    S_READX   = 21'h000020,
    S_READY   = 21'h000040,
    S_EXEC    = 21'h000080,
    S_WVX     = 21'h000100,
    S_CLS     = 21'h000200,
    S_RET     = 21'h000400,
    S_DRAW_RD = 21'h000800,
    S_DRAW_WR = 21'h001000,
    S_DRAW_END= 21'h002000,
    S_BCD     = 21'h004000,
    S_ST_RD   = 21'h008000,
    S_ST_WR   = 21'h010000,
    S_LD_RD   = 21'h020000,
    S_LD_WR   = 21'h040000,
    S_FIN     = 21'h080000,
    S_RESP    = 21'h100000
  } state_t;

  state_t state, state_next;
  logic   rsp_valid_next;
  logic   rsp_free;

  assign req_ready = (state == S_IDLE);
  assign rsp_free  = !rsp_valid || rsp_ready;

  always_comb begin
    cmd        = '0;
    cmd.mrd    = c8_pkg::MR_PC;
    cmd.mwr    = c8_pkg::MW_NONE;
    cmd.vrd    = c8_pkg::VR_X;
    cmd.vwr    = c8_pkg::VW_NONE;
    cmd.frd    = c8_pkg::FR_SEL;
    cmd.fwr    = c8_pkg::FW_NONE;
    state_next = state;
    unique case (state)
      S_INIT: begin
        cmd.mwr     = c8_pkg::MW_INIT;
        cmd.vwr     = c8_pkg::VW_INIT;
        cmd.fwr     = c8_pkg::FW_INIT;
        cmd.cnt_inc = 1'b1;
        if (stat.cnt_init_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.take  = 1'b1;
          cmd.fr_rd = 1'b1;
          if (req_cmd == c8_pkg::CMD_LOAD) cmd.mwr = c8_pkg::MW_LOAD;
          state_next = (req_cmd == c8_pkg::CMD_STEP) ? S_FETCH0 : S_RESP;
        end
      end
      S_FETCH0: state_next = S_FETCH1;
      S_FETCH1: begin
        cmd.op_hi  = 1'b1;
        cmd.mrd    = c8_pkg::MR_PC1;
        state_next = S_FETCH2;
      end
      S_FETCH2: begin
        cmd.op_lo  = 1'b1;
        cmd.pc_adv = 1'b1;
        state_next = S_READX;
      end
      S_READX: state_next = S_READY;
      S_READY: begin
        cmd.vx_cap = 1'b1;
        cmd.vrd    = c8_pkg::VR_Y;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec    = 1'b1;
        cmd.cnt_clr = 1'b1;
        unique case (stat.kind)
          c8_pkg::K_CLS:   state_next = S_CLS;
          c8_pkg::K_RET:   state_next = S_RET;
          c8_pkg::K_DRAW:  state_next = S_DRAW_RD;
          c8_pkg::K_BCD:   state_next = S_BCD;
          c8_pkg::K_STORE: state_next = S_ST_RD;
          c8_pkg::K_LOAD:  state_next = S_LD_RD;
          default:         state_next = stat.wr_vx ? S_WVX : S_FIN;
        endcase
      end
      S_WVX: begin
        cmd.vwr    = c8_pkg::VW_VX;
        state_next = S_FIN;
      end
      S_CLS: begin
        cmd.fwr     = c8_pkg::FW_CLR;
        cmd.cnt_inc = 1'b1;
        if (stat.cnt_row_last) state_next = S_FIN;
      end
      S_RET: begin
        cmd.ret_pc = 1'b1;
        state_next = S_FIN;
      end
      S_DRAW_RD: begin
        if (stat.draw_done) begin
          state_next = S_DRAW_END;
        end else begin
          cmd.mrd    = c8_pkg::MR_IDX;
          cmd.fr_rd  = 1'b1;
          cmd.frd    = c8_pkg::FR_DRAW;
          state_next = S_DRAW_WR;
        end
      end
      S_DRAW_WR: begin
        cmd.fwr     = c8_pkg::FW_DRAW;
        cmd.cnt_inc = 1'b1;
        state_next  = S_DRAW_RD;
      end
      S_DRAW_END: begin
        cmd.vwr    = c8_pkg::VW_HIT;
        state_next = S_FIN;
      end
      S_BCD: begin
        cmd.mwr     = c8_pkg::MW_BCD;
        cmd.cnt_inc = 1'b1;
        if (stat.cnt_bcd_last) state_next = S_FIN;
      end
      S_ST_RD: begin
        cmd.vrd    = c8_pkg::VR_CNT;
        state_next = S_ST_WR;
      end
      S_ST_WR: begin
        cmd.mwr     = c8_pkg::MW_STORE;
        cmd.cnt_inc = 1'b1;
        state_next  = stat.cnt_x_last ? S_FIN : S_ST_RD;
      end
      S_LD_RD: begin
        cmd.mrd    = c8_pkg::MR_IDX;
        state_next = S_LD_WR;
      end
      S_LD_WR: begin
        cmd.vwr     = c8_pkg::VW_LOAD;
        cmd.cnt_inc = 1'b1;
        state_next  = stat.cnt_x_last ? S_FIN : S_LD_RD;
      end
      S_FIN: begin
        cmd.tick   = 1'b1;
        state_next = S_RESP;
      end
      S_RESP: begin
        if (rsp_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_INIT;
    endcase
  end

  always_comb begin
    if (cmd.out_load) rsp_valid_next = 1'b1;
    else if (rsp_ready) rsp_valid_next = 1'b0;
    else rsp_valid_next = rsp_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule
